FILE: design/tmhs_pkg.sv
package tmhs_pkg;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_ADJUST = 3'd1,
      OP_CANCEL = 3'd2,
      OP_TICK   = 3'd3,
      OP_QUERY  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_EXPIRED = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_NEXT    = 2'd2,
      KIND_FULL    = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_CANC_WR,
      ST_TOP_RD,
      ST_TOP_CHK,
      ST_RM_RD,
      ST_RM_MV,
      ST_EMIT
   } state_type;

   localparam logic [31:0] NEXT_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] NEXT_NONE = 32'hFFFF_FFFF;

endpackage

FILE: design/timer_min_heap_scheduler.sv
// channel | direction | payload
// req     | in        | tdata: opcode, timer_id, timeout_ms, elapsed_ms
// rsp     | out       | tdata: expired_id, next_ms ; tuser: kind ; tlast: last
// add, adjust: a level moved up takes UP_RD, UP_CMP and the swap; down takes DN_RDL, DN_RDR, DN_CMP and the swap
// tick and query: read and check the top, plus a sift down per timer removed from the top
// one read port per store: every compare waits on a registered read
// after reset the id table is swept clear, all ID_LIMIT entries, with req_tready low
// a waiting result holds the sequencer until rsp_tready; one item is in work at a time
module timer_min_heap_scheduler
   import tmhs_pkg::*;
#(
   parameter int HEAP_SLOTS = 64,
   parameter int ID_LIMIT   = 1024,
   parameter int TIME_BITS  = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // opcode[2:0], timer_id[12:3], timeout_ms[43:13], elapsed_ms[74:44]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // expired_id[9:0], next_ms[41:10]
   output logic [1:0]   rsp_tuser,   // kind[1:0]
   output logic         rsp_tlast
);

   localparam int SW = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
   localparam int CW = $clog2(HEAP_SLOTS + 1);
   localparam int IW = (ID_LIMIT > 1) ? $clog2(ID_LIMIT) : 1;
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
   localparam logic [CW-1:0] FULL = CW'(HEAP_SLOTS);

   typedef struct packed {
      logic                 canc;
      logic [TIME_BITS-1:0] exp;
      logic [9:0]           id;
   } entry_type;

   entry_type      heap_mem [HEAP_SLOTS];
   logic [CW-1:0]  map_mem  [ID_LIMIT];

   state_type state_ff, state_in;
   opcode_type op_ff, op_in;
   logic [9:0]  tid_ff, tid_in;
   logic [30:0] tmo_ff, tmo_in;
   logic [30:0] ela_ff, ela_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [SW-1:0] i_ff, i_in, j_ff, j_in;
   logic up_ff, up_in;
   logic down_ff, down_in;
   logic loop_ff, loop_in;
   logic cont_ff, cont_in;
   logic pend_valid_ff, pend_valid_in;
   logic [9:0] pend_ff, pend_in;
   entry_type a_ff, a_in, b_ff, b_in, m_ff, m_in;
   logic [SW-1:0] mi_ff, mi_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic clearing_ff, clearing_in;
   kind_type kind_ff, kind_in;
   logic [9:0] oid_ff, oid_in;
   logic [31:0] onext_ff, onext_in;
   logic olast_ff, olast_in;

   // memory access
   logic hwe;
   logic [SW-1:0] hwa, hra;
   entry_type hwd, hrd;
   logic mwe;
   logic [IW-1:0] mwa, mra;
   logic [CW-1:0] mwd, mrd;

   always_ff @(posedge clock) begin
      if (hwe) heap_mem[hwa] <= hwd;
      hrd <= heap_mem[hra];
      if (mwe) map_mem[mwa] <= mwd;
      mrd <= map_mem[mra];
   end

   // shared arithmetic: one saturating adder and one time comparator, muxed by state
   logic [TIME_BITS-1:0] add_a, add_b;
   logic [TIME_BITS:0]   add_s;
   logic [TIME_BITS-1:0] sat_s;
   logic [TIME_BITS-1:0] cmp_a, cmp_b;
   logic cmp_lt;
   assign add_a  = now_ff;
   assign add_b  = (state_ff == ST_DECODE && op_ff == OP_TICK) ? TIME_BITS'(ela_ff)
                                                               : TIME_BITS'(tmo_ff);
   assign add_s  = {1'b0, add_a} + {1'b0, add_b};
   assign sat_s  = add_s[TIME_BITS] ? TMAX : add_s[TIME_BITS-1:0];
   assign cmp_lt = cmp_a < cmp_b;

   always_comb begin
      cmp_a = a_ff.exp; cmp_b = hrd.exp;
      unique case (state_ff)
         ST_DN_RDR: begin
            cmp_a = hrd.exp; cmp_b = a_ff.exp;
         end
         ST_DN_CMP: begin
            cmp_a = hrd.exp; cmp_b = m_ff.exp;
         end
         ST_TOP_CHK: begin
            cmp_a = now_ff; cmp_b = hrd.exp;
         end
         default: begin
         end
      endcase
   end

   logic [SW+1:0] lch, rch;
   logic l_ok, r_ok;
   assign lch  = {1'b0, i_ff, 1'b1};
   assign rch  = {1'b0, i_ff, 1'b0} + (SW+2)'(2);
   assign l_ok = lch < (SW+2)'(cnt_ff);
   assign r_ok = rch < (SW+2)'(cnt_ff);

   logic [TIME_BITS-1:0] diff;
   assign diff = hrd.exp - now_ff;

   entry_type fresh;
   logic [SW-1:0] mslot;
   logic ov;
   assign fresh = '{canc: 1'b0, exp: sat_s, id: tid_ff};
   assign mslot = SW'(mrd - CW'(1));
   assign ov    = 32'(tid_ff) >= 32'(ID_LIMIT);

   state_type finish;
   assign finish = loop_ff ? ST_TOP_RD : ST_EMIT;

   always_comb begin
      state_in = state_ff; op_in = op_ff; tid_in = tid_ff; tmo_in = tmo_ff; ela_in = ela_ff;
      cnt_in = cnt_ff; now_in = now_ff; i_in = i_ff; j_in = j_ff; up_in = up_ff;
      down_in = down_ff; loop_in = loop_ff; cont_in = cont_ff;
      pend_valid_in = pend_valid_ff; pend_in = pend_ff;
      a_in = a_ff; b_in = b_ff; m_in = m_ff; mi_in = mi_ff;
      clr_in = clr_ff; clearing_in = clearing_ff;
      kind_in = kind_ff; oid_in = oid_ff; onext_in = onext_ff; olast_in = olast_ff;
      hwe = 1'b0; hwa = i_ff; hwd = a_ff; hra = i_ff;
      mwe = 1'b0; mwa = IW'(a_ff.id); mwd = '0; mra = IW'(tid_ff);
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (clearing_ff) begin
               mwe = 1'b1; mwa = clr_ff; mwd = '0;
               clr_in = clr_ff + IW'(1);
               if (clr_ff == IW'(ID_LIMIT - 1)) clearing_in = 1'b0;
            end else begin
               req_tready = 1'b1;
               mra = IW'(req_tdata[12:3]);
               if (req_tvalid) begin
                  op_in  = opcode_type'(req_tdata[2:0]);
                  tid_in = req_tdata[12:3];
                  tmo_in = req_tdata[43:13];
                  ela_in = req_tdata[74:44];
                  state_in = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            kind_in = KIND_DONE; oid_in = '0; onext_in = '0; olast_in = 1'b1;
            cont_in = 1'b0; pend_valid_in = 1'b0; loop_in = 1'b0;
            up_in = 1'b1; down_in = 1'b0;
            state_in = ST_EMIT;
            unique case (op_ff)
               OP_ADD: begin
                  if (!ov) begin
                     if (mrd != '0) begin
                        // re-arm: sift up then down
                        i_in = mslot; a_in = fresh;
                        hwe = 1'b1; hwa = mslot; hwd = fresh;
                        down_in = 1'b1;
                        state_in = ST_UP_RD;
                     end else if (cnt_ff >= FULL) begin
                        kind_in = KIND_FULL;
                     end else begin
                        i_in = SW'(cnt_ff); a_in = fresh;
                        hwe = 1'b1; hwa = SW'(cnt_ff); hwd = fresh;
                        mwe = 1'b1; mwa = IW'(tid_ff); mwd = cnt_ff + CW'(1);
                        cnt_in = cnt_ff + CW'(1);
                        state_in = ST_UP_RD;
                     end
                  end
               end
               OP_ADJUST: begin
                  if (!ov && mrd != '0) begin
                     i_in = mslot; a_in = fresh;
                     hwe = 1'b1; hwa = mslot; hwd = fresh;
                     up_in = 1'b0;
                     state_in = ST_DN_RDL;
                  end
               end
               OP_CANCEL: begin
                  if (!ov && mrd != '0) begin
                     i_in = mslot; hra = mslot;
                     state_in = ST_CANC_WR;
                  end
               end
               OP_TICK: begin
                  now_in = sat_s;
                  loop_in = 1'b1;
                  state_in = ST_TOP_RD;
               end
               OP_QUERY: begin
                  loop_in = 1'b1;
                  state_in = ST_TOP_RD;
               end
               default: state_in = ST_EMIT;
            endcase
         end
         // sift up: a_ff is the entry at i_ff
         ST_UP_RD: begin
            if (i_ff == '0) begin
               up_in = 1'b0;
               state_in = down_ff ? ST_DN_RDL : finish;
            end else begin
               j_in = (i_ff - SW'(1)) >> 1;
               hra = (i_ff - SW'(1)) >> 1;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (cmp_lt) begin
               b_in = hrd;
               state_in = ST_SWAP_A;
            end else begin
               up_in = 1'b0;
               state_in = down_ff ? ST_DN_RDL : finish;
            end
         end
         // swap: slot i_ff gets b_ff, slot j_ff gets a_ff
         ST_SWAP_A: begin
            hwe = 1'b1; hwa = i_ff; hwd = b_ff;
            mwe = 1'b1; mwa = IW'(b_ff.id); mwd = CW'(i_ff) + CW'(1);
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            hwe = 1'b1; hwa = j_ff; hwd = a_ff;
            mwe = 1'b1; mwa = IW'(a_ff.id); mwd = CW'(j_ff) + CW'(1);
            i_in = j_ff;
            state_in = up_ff ? ST_UP_RD : ST_DN_RDL;
         end
         // sift down from i_ff, a_ff is that entry
         ST_DN_RDL: begin
            hra = lch[SW-1:0];
            state_in = ST_DN_RDR;
         end
         ST_DN_RDR: begin
            hra = rch[SW-1:0];
            m_in = a_ff; mi_in = i_ff;
            if (l_ok && cmp_lt) begin
               m_in = hrd; mi_in = lch[SW-1:0];
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (r_ok && cmp_lt) begin
               b_in = hrd; j_in = rch[SW-1:0];
               state_in = ST_SWAP_A;
            end else if (mi_ff != i_ff) begin
               b_in = m_ff; j_in = mi_ff;
               state_in = ST_SWAP_A;
            end else begin
               state_in = finish;
            end
         end
         // cancel: mark only
         ST_CANC_WR: begin
            hwe = 1'b1; hwa = i_ff;
            hwd = '{canc: 1'b1, exp: hrd.exp, id: hrd.id};
            state_in = ST_EMIT;
         end
         // top of heap for tick and query
         ST_TOP_RD: begin
            hra = '0;
            state_in = ST_TOP_CHK;
         end
         ST_TOP_CHK: begin
            a_in = hrd;
            if (cnt_ff != '0 && hrd.canc) begin
               state_in = ST_RM_RD;
            end else if (op_ff == OP_QUERY) begin
               kind_in = KIND_NEXT; olast_in = 1'b1; cont_in = 1'b0;
               if (cnt_ff == '0) onext_in = NEXT_NONE;
               else if (!cmp_lt) onext_in = '0;
               else onext_in = (diff > TIME_BITS'(NEXT_MAX)) ? NEXT_MAX : diff[31:0];
               state_in = ST_EMIT;
            end else if (cnt_ff == '0 || cmp_lt) begin
               // nothing more expired: flush the held id as the final item
               kind_in = pend_valid_ff ? KIND_EXPIRED : KIND_DONE;
               oid_in = pend_valid_ff ? pend_ff : '0;
               onext_in = '0; olast_in = 1'b1; cont_in = 1'b0;
               state_in = ST_EMIT;
            end else begin
               pend_in = hrd.id; pend_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  kind_in = KIND_EXPIRED; oid_in = pend_ff; onext_in = '0;
                  olast_in = 1'b0; cont_in = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_RM_RD;
               end
            end
         end
         // remove top: a_ff is the top, the last entry moves to slot 0
         ST_RM_RD: begin
            mwe = 1'b1; mwa = IW'(a_ff.id); mwd = '0;
            hra = SW'(cnt_ff - CW'(1));
            cnt_in = cnt_ff - CW'(1);
            state_in = (cnt_ff == CW'(1)) ? ST_TOP_RD : ST_RM_MV;
         end
         ST_RM_MV: begin
            a_in = hrd; i_in = '0; up_in = 1'b0;
            hwe = 1'b1; hwa = '0; hwd = hrd;
            mwe = 1'b1; mwa = IW'(hrd.id); mwd = CW'(1);
            state_in = ST_DN_RDL;
         end
         ST_EMIT: begin
            if (rsp_tready) state_in = cont_ff ? ST_RM_RD : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {6'd0, onext_ff, oid_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cnt_ff <= '0; now_ff <= '0;
         clr_ff <= '0; clearing_ff <= 1'b1;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; now_ff <= now_in;
         clr_ff <= clr_in; clearing_ff <= clearing_in;
      end
      op_ff <= op_in; tid_ff <= tid_in; tmo_ff <= tmo_in; ela_ff <= ela_in;
      i_ff <= i_in; j_ff <= j_in; up_ff <= up_in; down_ff <= down_in;
      loop_ff <= loop_in; cont_ff <= cont_in;
      pend_valid_ff <= pend_valid_in; pend_ff <= pend_in;
      a_ff <= a_in; b_ff <= b_in; m_ff <= m_in; mi_ff <= mi_in;
      kind_ff <= kind_in; oid_ff <= oid_in; onext_ff <= onext_in; olast_ff <= olast_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast));
   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid));
   assert property (@(posedge clock) disable iff (reset) req_tvalid && req_tready |=> !req_tready);
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= FULL);
   assert property (@(posedge clock) disable iff (reset) clearing_ff |-> !req_tready);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import tmhs_pkg::*;

   localparam int SLOTS = 64;
   localparam int IDS = 1024;
   localparam longint unsigned TMAX = 64'hFFFF_FFFF_FFFF;

   typedef struct packed {
      kind_type    kind;
      logic [9:0]  expired_id;
      logic [31:0] next_ms;
      logic        last;
   } timer_result_type;

   typedef struct {
      int unsigned     id;
      longint unsigned expiry;
      bit              cancelled;
   } timer_entry_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   timer_min_heap_scheduler dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   timer_entry_type  heap_model[SLOTS];
   int unsigned      slot_plus1[IDS];
   int unsigned      heap_fill;
   longint unsigned  clock_ms;
   timer_result_type pending_results[$];
   int               errors = 0;
   int               items_sent = 0;
   int               results_seen = 0;
   int               expiries_seen = 0;
   int               burst_left = 0;

   function automatic longint unsigned sat_time(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      if (s < a || s > TMAX) return TMAX;
      return s;
   endfunction

   function automatic void swap_entries(int unsigned a, int unsigned b);
      timer_entry_type t;
      t = heap_model[a];
      heap_model[a] = heap_model[b];
      heap_model[b] = t;
      slot_plus1[heap_model[a].id] = a + 1;
      slot_plus1[heap_model[b].id] = b + 1;
   endfunction

   function automatic void bubble_up(int unsigned i);
      int unsigned p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (heap_model[p].expiry <= heap_model[i].expiry) break;
         swap_entries(p, i);
         i = p;
      end
   endfunction

   function automatic void bubble_down(int unsigned i);
      int unsigned m, l, r;
      forever begin
         m = i;
         l = 2 * i + 1;
         r = 2 * i + 2;
         if (l < heap_fill && heap_model[l].expiry < heap_model[m].expiry) m = l;
         if (r < heap_fill && heap_model[r].expiry < heap_model[m].expiry) m = r;
         if (m == i) break;
         swap_entries(i, m);
         i = m;
      end
   endfunction

   function automatic void drop_slot(int unsigned i);
      int unsigned e;
      if (heap_fill == 0 || i >= heap_fill) return;
      e = heap_fill - 1;
      if (i < e) begin
         swap_entries(i, e);
         slot_plus1[heap_model[e].id] = 0;
         heap_fill--;
         bubble_up(i);
         bubble_down(i);
      end else begin
         slot_plus1[heap_model[e].id] = 0;
         heap_fill--;
      end
   endfunction

   function automatic void purge_cancelled();
      while (heap_fill > 0 && heap_model[0].cancelled) drop_slot(0);
   endfunction

   function automatic void push_result(kind_type k, int unsigned id, logic [31:0] nxt,
                                       bit lst);
      timer_result_type r;
      r.kind = k;
      r.expired_id = id[9:0];
      r.next_ms = nxt;
      r.last = lst;
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic void predict_timer_op(logic [2:0] op, int unsigned id,
                                            longint unsigned tmo, longint unsigned ela);
      int unsigned s;
      int n;
      longint unsigned d;
      logic [31:0] nxt;
      case (op)
         OP_ADD: begin
            s = slot_plus1[id];
            if (s != 0) begin
               s--;
               heap_model[s].expiry = sat_time(clock_ms, tmo);
               heap_model[s].cancelled = 0;
               bubble_up(s);
               bubble_down(s);
            end else if (heap_fill >= SLOTS) begin
               push_result(KIND_FULL, 0, 0, 1);
               return;
            end else begin
               s = heap_fill++;
               heap_model[s].id = id;
               heap_model[s].expiry = sat_time(clock_ms, tmo);
               heap_model[s].cancelled = 0;
               slot_plus1[id] = s + 1;
               bubble_up(s);
            end
            push_result(KIND_DONE, 0, 0, 1);
         end
         OP_ADJUST: begin
            if (slot_plus1[id] != 0) begin
               s = slot_plus1[id] - 1;
               heap_model[s].expiry = sat_time(clock_ms, tmo);
               heap_model[s].cancelled = 0;
               bubble_down(s);
            end
            push_result(KIND_DONE, 0, 0, 1);
         end
         OP_CANCEL: begin
            if (slot_plus1[id] != 0) heap_model[slot_plus1[id] - 1].cancelled = 1;
            push_result(KIND_DONE, 0, 0, 1);
         end
         OP_TICK: begin
            n = 0;
            clock_ms = sat_time(clock_ms, ela);
            forever begin
               purge_cancelled();
               if (heap_fill == 0 || heap_model[0].expiry > clock_ms) break;
               push_result(KIND_EXPIRED, heap_model[0].id, 0, 0);
               n++;
               drop_slot(0);
            end
            if (n == 0) push_result(KIND_DONE, 0, 0, 1);
            else pending_results[$].last = 1;
         end
         OP_QUERY: begin
            purge_cancelled();
            if (heap_fill == 0) nxt = NEXT_NONE;
            else if (heap_model[0].expiry <= clock_ms) nxt = 0;
            else begin
               d = heap_model[0].expiry - clock_ms;
               nxt = d > NEXT_MAX ? NEXT_MAX : d[31:0];
            end
            push_result(KIND_NEXT, 0, nxt, 1);
         end
         default: push_result(KIND_DONE, 0, 0, 1);
      endcase
   endfunction

   task automatic send_timer_op(logic [2:0] op, int unsigned id, longint unsigned tmo,
                                longint unsigned ela);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) == 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= {5'd0, ela[30:0], tmo[30:0], id[9:0], op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_timer_op(op, id, tmo, ela);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic longint unsigned rand_delay();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 31'h7FFF_FFFF;
         2: return $urandom_range(0, 20);
         default: return $urandom_range(0, 400);
      endcase
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      int ph;
      ph = $urandom_range(0, 99);
      rsp_tready <= (results_seen / 50) % 3 == 0 ? 1'b1 : ph < 65;
   end

   always @(posedge clock) begin
      timer_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected item kind=%0d", rsp_tuser);
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tuser == KIND_EXPIRED) expiries_seen++;
            if (rsp_tuser != exp_r.kind) begin
               $error("kind expected %0d actual %0d", exp_r.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[9:0] != exp_r.expired_id) begin
               $error("expired_id expected %0d actual %0d", exp_r.expired_id, rsp_tdata[9:0]);
               errors++;
            end
            if (rsp_tdata[41:10] != exp_r.next_ms) begin
               $error("next_ms expected %0d actual %0d", $signed(exp_r.next_ms),
                      $signed(rsp_tdata[41:10]));
               errors++;
            end
            if (rsp_tlast != exp_r.last) begin
               $error("last expected %0d actual %0d", exp_r.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_timer_op(OP_QUERY, 0, 0, 0);
      send_timer_op(OP_TICK, 0, 0, 0);
      send_timer_op(OP_ADD, 0, 10, 0);
      send_timer_op(OP_ADD, 1023, 31'h7FFF_FFFF, 0);
      send_timer_op(OP_ADD, 5, 0, 0);
      send_timer_op(OP_QUERY, 0, 0, 0);
      send_timer_op(OP_ADD, 7, 30, 0);
      send_timer_op(OP_ADJUST, 7, 1, 0);
      send_timer_op(OP_ADJUST, 9, 3, 0);
      send_timer_op(OP_ADD, 0, 2, 0);
      send_timer_op(OP_CANCEL, 5, 0, 0);
      send_timer_op(OP_CANCEL, 600, 0, 0);
      send_timer_op(OP_QUERY, 0, 0, 0);
      send_timer_op(OP_TICK, 0, 0, 5);
      send_timer_op(3'd5, 682, 31'h2AAA_AAAA, 31'h5555_5555);
      send_timer_op(3'd7, 341, 31'h5555_5555, 31'h2AAA_AAAA);
      send_timer_op(3'd6, 0, 0, 0);
      send_timer_op(OP_TICK, 0, 0, 31'h7FFF_FFFF);
      send_timer_op(OP_QUERY, 0, 0, 0);
      wait_drained();
   endtask

   task automatic test_heap_full();
      for (int i = 0; i < SLOTS; i++) send_timer_op(OP_ADD, 100 + i, $urandom_range(1, 500), 0);
      send_timer_op(OP_ADD, 900, 1, 0);
      send_timer_op(OP_ADD, 130, 0, 0);
      for (int i = 0; i < 6; i++) send_timer_op(OP_CANCEL, 100 + 3 * i, 0, 0);
      send_timer_op(OP_QUERY, 0, 0, 0);
      send_timer_op(OP_TICK, 0, 0, 600);
      wait_drained();
   endtask

   task automatic test_random_ops();
      int unsigned op, id;
      for (int i = 0; i < 270; i++) begin
         op = $urandom_range(0, 99);
         id = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 40);
         if (op < 35) send_timer_op(OP_ADD, id, rand_delay(), 0);
         else if (op < 50) send_timer_op(OP_ADJUST, id, rand_delay(), 0);
         else if (op < 62) send_timer_op(OP_CANCEL, id, 0, 0);
         else if (op < 82) send_timer_op(OP_TICK, 0, 0, rand_delay());
         else if (op < 96) send_timer_op(OP_QUERY, 0, 0, 0);
         else send_timer_op($urandom_range(5, 7), $urandom, $urandom, $urandom);
         if (i == 135) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      foreach (slot_plus1[i]) slot_plus1[i] = 0;
      heap_fill = 0;
      clock_ms = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      test_directed();
      test_heap_full();
      test_random_ops();
      repeat (50) @(posedge clock);
      $display("sent %0d items, checked %0d results including %0d expiries",
               items_sent, results_seen, expiries_seen);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
